// File: sv/vn_pkg.sv
// Shared types and constants for the 3D vector normalizer.
package vn_pkg;

  localparam int unsigned COMP_W      = 32;
  localparam int unsigned RAD_W       = 2 * COMP_W;
  localparam int unsigned REM_W       = COMP_W + 4;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned SQRT_STAGES = COMP_W;
  localparam int unsigned DIV_STAGES  = QUO_W;

  typedef logic [COMP_W-1:0] comp_t;

  // Travels with an item through the square-root pipeline.
  typedef struct packed {
    comp_t      mag_x;
    comp_t      mag_y;
    comp_t      mag_z;
    logic [2:0] neg;
  } vn_sq_side_t;

  // Travels with an item through the divider pipeline.
  typedef struct packed {
    comp_t      len;
    logic [2:0] neg;
    logic       too_small;
  } vn_dv_side_t;

endpackage

// File: sv/vn_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module vn_sqrt import vn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  vn_sq_side_t       in_side,
  output logic              out_vld,
  output comp_t             out_root,
  output vn_sq_side_t       out_side
);

  logic              vld_r  [0:SQRT_STAGES-1];
  logic [REM_W-1:0]  rem_r  [0:SQRT_STAGES-1];
  comp_t             root_r [0:SQRT_STAGES-1];
  logic [RAD_W-1:0]  rad_r  [0:SQRT_STAGES-1];
  vn_sq_side_t       side_r [0:SQRT_STAGES-1];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic              p_vld;
    logic [REM_W-1:0]  p_rem;
    comp_t             p_root;
    logic [RAD_W-1:0]  p_rad;
    vn_sq_side_t       p_side;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_root = root_r[s-1];
      assign p_rad  = rad_r[s-1];
      assign p_side = side_r[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, p_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= p_vld;
      end
      rem_r[s]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[s] <= {p_root[COMP_W-2:0], ge};
      rad_r[s]  <= {p_rad[RAD_W-3:0], 2'b00};
      side_r[s] <= p_side;
    end
  end

  assign out_vld  = vld_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1];
  assign out_side = side_r[SQRT_STAGES-1];

endmodule

// File: sv/vn_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
module vn_div import vn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  comp_t             in_mag [0:2],
  input  vn_dv_side_t       in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo [0:2],
  output vn_dv_side_t       out_side
);

  logic              vld_r  [0:DIV_STAGES-1];
  vn_dv_side_t       side_r [0:DIV_STAGES-1];
  comp_t             rem_r  [0:DIV_STAGES-1][0:2];
  logic [QUO_W-1:0]  quo_r  [0:DIV_STAGES-1][0:2];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic        p_vld;
    vn_dv_side_t p_side;

    if (s == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[s-1];
      assign p_side = side_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= p_vld;
      end
      side_r[s] <= p_side;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [COMP_W:0]  sh;
      logic [QUO_W-1:0] p_quo;
      logic             ge;

      // first step: (mag>>1)*2 + mag[0] is mag itself
      if (s == 0) begin : g_first
        assign sh    = {1'b0, in_mag[l]};
        assign p_quo = '0;
      end else begin : g_next
        assign sh    = {rem_r[s-1][l], 1'b0};
        assign p_quo = quo_r[s-1][l];
      end

      assign ge = (sh >= {1'b0, p_side.len});

      always_ff @(posedge clk) begin
        rem_r[s][l] <= ge ? COMP_W'(sh - {1'b0, p_side.len}) : sh[COMP_W-1:0];
        quo_r[s][l] <= {p_quo[QUO_W-2:0], ge};
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_quo[l] = quo_r[DIV_STAGES-1][l];
  end

endmodule

// File: sv/vector3_normalize.sv
// Top level of the pipelined 3D vector normalizer.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start / busy       | in_comp_x, in_comp_y, in_comp_z
//   result   | out_valid (strobe) | out_unit_x/y/z, out_length, out_too_small
//   config   | cfg_we             | cfg_wdata (min_magnitude)
//
// One beat enters per cycle; busy is always low. Every beat gives one result
// beat, passing through one stage for abs and square, one for the sum, 32
// square-root stages (one root bit each), 31 divider stages (one quotient bit
// each) and the output register. Synchronous active-low reset clears the
// valid bits only and sets min_magnitude to 1. The receiver cannot stall, so
// the pipeline never holds.
module vector3_normalize import vn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_comp_x,
  input  logic signed [31:0] in_comp_y,
  input  logic signed [31:0] in_comp_z,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_unit_x,
  output logic signed [31:0] out_unit_y,
  output logic signed [31:0] out_unit_z,
  output logic [31:0]        out_length,
  output logic               out_too_small
);

  // Threshold register.
  comp_t min_mag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r <= comp_t'(1);
    end else if (cfg_we) begin
      min_mag_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Stage 1: magnitudes and squares.
  logic        accept;
  comp_t       mag_x, mag_y, mag_z;
  logic        sq_vld_r;
  vn_sq_side_t sq_side_r;
  logic [RAD_W-1:0] sq_x_r, sq_y_r, sq_z_r;

  assign accept = start && !busy;
  assign mag_x  = in_comp_x[31] ? comp_t'(-in_comp_x) : comp_t'(in_comp_x);
  assign mag_y  = in_comp_y[31] ? comp_t'(-in_comp_y) : comp_t'(in_comp_y);
  assign mag_z  = in_comp_z[31] ? comp_t'(-in_comp_z) : comp_t'(in_comp_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= accept;
    end
    sq_x_r    <= RAD_W'(mag_x) * RAD_W'(mag_x);
    sq_y_r    <= RAD_W'(mag_y) * RAD_W'(mag_y);
    sq_z_r    <= RAD_W'(mag_z) * RAD_W'(mag_z);
    sq_side_r <= '{mag_x: mag_x, mag_y: mag_y, mag_z: mag_z,
                   neg: {in_comp_z[31], in_comp_y[31], in_comp_x[31]}};
  end

  // Stage 2: sum of squares; cannot overflow 64 bits (max 3 * 2^62).
  logic             sum_vld_r;
  logic [RAD_W-1:0] sum_r;
  vn_sq_side_t      sum_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= sq_vld_r;
    end
    sum_r      <= sq_x_r + sq_y_r + sq_z_r;
    sum_side_r <= sq_side_r;
  end

  // Square-root pipeline.
  logic        rt_vld;
  comp_t       rt_root;
  vn_sq_side_t rt_side;
  vn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sum_vld_r),
    .in_rad   (sum_r),
    .in_side  (sum_side_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // Threshold check on the truncated length, then divide each magnitude.
  comp_t            dv_mag [0:2];
  vn_dv_side_t      dv_side;
  logic             dq_vld;
  logic [QUO_W-1:0] dq_quo [0:2];
  vn_dv_side_t      dq_side;

  assign dv_mag[0] = rt_side.mag_x;
  assign dv_mag[1] = rt_side.mag_y;
  assign dv_mag[2] = rt_side.mag_z;
  assign dv_side   = '{len: rt_root, neg: rt_side.neg,
                       too_small: (rt_root <= min_mag_r)};

  vn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rt_vld),
    .in_mag   (dv_mag),
    .in_side  (dv_side),
    .out_vld  (dq_vld),
    .out_quo  (dq_quo),
    .out_side (dq_side)
  );

  // Output register: apply signs, zero the units when too small.
  logic [COMP_W-1:0] unit_nxt [0:2];
  logic [COMP_W-1:0] unit_r   [0:2];
  logic              valid_r;
  comp_t             length_r;
  logic              small_r;

  for (genvar l = 0; l < 3; l++) begin : g_sign
    always_comb begin
      if (dq_side.too_small) begin
        unit_nxt[l] = '0;
      end else if (dq_side.neg[l]) begin
        unit_nxt[l] = -{1'b0, dq_quo[l]};
      end else begin
        unit_nxt[l] = {1'b0, dq_quo[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dq_vld;
    end
    unit_r   <= unit_nxt;
    length_r <= dq_side.len;
    small_r  <= dq_side.too_small;
  end

  assign out_valid     = valid_r;
  assign out_unit_x    = unit_r[0];
  assign out_unit_y    = unit_r[1];
  assign out_unit_z    = unit_r[2];
  assign out_length    = length_r;
  assign out_too_small = small_r;

  // A flagged beat carries zero units.
  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_small |-> out_unit_x == 0 && out_unit_y == 0 && out_unit_z == 0)
    else $error("too_small beat with nonzero unit component");

  // A beat that passed the threshold has a nonzero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_small |-> out_length != 0)
    else $error("normalized beat with zero length");

  // Unit components stay within [-1.0, 1.0] in Q2.30.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= 32'sh4000_0000 && out_unit_x >= -32'sh4000_0000 &&
                  out_unit_y <= 32'sh4000_0000 && out_unit_y >= -32'sh4000_0000 &&
                  out_unit_z <= 32'sh4000_0000 && out_unit_z >= -32'sh4000_0000)
    else $error("unit component out of range");

endmodule
